// ----- rtl/pdd_pkg.sv -----
// ----------------------------------------------------------------------------
// pdd_pkg
// Shared types, constants and codes of the payload deploy detector.
// ----------------------------------------------------------------------------
package pdd_pkg;

  // word widths
  localparam int unsigned AltW     = 32;
  localparam int unsigned TimeW    = 32;
  localparam int unsigned ThrW     = 16;
  localparam int unsigned GapW     = 16;
  localparam int unsigned LimW     = 31;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 32;

  // climb rate arithmetic: |delta| * 1000 fits 42 bits
  localparam int unsigned MagW     = 32;
  localparam int unsigned MulKW    = 10;
  localparam int unsigned MulK     = 1000;
  localparam int unsigned DivW     = MagW + MulKW;
  localparam int unsigned DivCntW  = $clog2(DivW);

  // register reset values
  localparam logic [ThrW-1:0]        RstVelThr  = ThrW'(500);
  localparam logic signed [AltW-1:0] RstMinAlt  = AltW'(121920);
  localparam logic [GapW-1:0]        RstMaxGap  = GapW'(1000);
  localparam logic [LimW-1:0]        RstAltLim  = LimW'(10000000);

  // item kind
  typedef enum logic {
    ACT_SAMPLE = 1'b0,
    ACT_ARM    = 1'b1
  } pdd_act_e;

  // register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_VEL_THR   = 2'd0,
    CFG_MIN_ALT   = 2'd1,
    CFG_MAX_GAP   = 2'd2,
    CFG_ALT_LIMIT = 2'd3
  } pdd_cfg_idx_e;

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_MUL,
    S_DIV,
    S_FIN,
    S_DONE
  } pdd_state_e;

  typedef struct packed {
    pdd_act_e                action;
    logic signed [AltW-1:0]  altitude_cm;
    logic [TimeW-1:0]        time_ms;
  } in_word_t;

  typedef struct packed {
    logic                    deploy_now;
    logic                    rate_valid;
    logic signed [AltW-1:0]  climb_rate;
    logic                    deployed;
  } out_word_t;

  typedef struct packed {
    logic [CfgIdxW-1:0]      index;
    logic [CfgDataW-1:0]     value;
  } cfg_word_t;

  typedef struct packed {
    logic [ThrW-1:0]         velocity_threshold;
    logic signed [AltW-1:0]  min_altitude;
    logic [GapW-1:0]         max_time_gap;
    logic [LimW-1:0]         altitude_limit;
  } cfg_t;

endpackage

// ----- rtl/pdd_if.sv -----
// ----------------------------------------------------------------------------
// pdd channel interfaces
// Valid/ready channels for sample words, result words and register writes.
// ----------------------------------------------------------------------------
interface pdd_in_if;
  logic              valid;
  logic              ready;
  pdd_pkg::in_word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface pdd_out_if;
  logic               valid;
  logic               ready;
  pdd_pkg::out_word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface pdd_cfg_if;
  logic               valid;
  logic               ready;
  pdd_pkg::cfg_word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/payload_deploy_detector_unit.sv -----
// ----------------------------------------------------------------------------
// payload_deploy_detector_unit
// Climb rate from successive altitude samples and one-shot deploy decision.
// ----------------------------------------------------------------------------
// a sample with a valid rate goes EVAL, MUL, DIV (the 42-step divider), FIN,
//   DONE; an arm word, an ignored or a rate-less sample goes EVAL, DONE
// a new word is taken only in IDLE, after the last result is loaded for output
// a finished result waits in the output register while the next word enters
// reset: asynchronous, clears history, deployed latch and registers to defaults
// ----------------------------------------------------------------------------
module payload_deploy_detector_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  pdd_in_if.sink     in_i,
  pdd_out_if.source  out_o,
  pdd_cfg_if.sink    cfg_i
);

  pdd_pkg::cfg_t                 cfg;
  pdd_pkg::pdd_state_e           state_q, state_d;
  pdd_pkg::in_word_t             item_q;
  pdd_pkg::out_word_t            res_q, out_q;
  logic                          out_valid_q;
  logic                          deployed_q;
  logic signed [pdd_pkg::AltW-1:0] last_alt_q;
  logic [pdd_pkg::TimeW-1:0]     last_time_q;
  logic [pdd_pkg::GapW-1:0]      gap_q;
  logic                          dneg_q;
  logic [pdd_pkg::MagW-1:0]      dmag_q;

  // sequencer controls
  logic in_ready, item_load, eval_en, div_start, fin_en, out_load, out_free;
  logic clr_state;

  // evaluation signals
  logic [pdd_pkg::AltW:0]        alt_ext, last_ext, d_pos, d_neg, alt_neg;
  logic [pdd_pkg::MagW-1:0]      alt_mag;
  logic [pdd_pkg::TimeW-1:0]     gap;
  logic                          rate_ok;
  logic [pdd_pkg::DivW-1:0]      product;
  logic                          div_done;
  logic [pdd_pkg::DivW-1:0]      quo;
  logic signed [pdd_pkg::AltW-1:0] rate_sat;
  logic                          rate_pos, fire;

  pdd_cfg_regs u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      pdd_pkg::S_IDLE: if (in_i.valid) state_d = pdd_pkg::S_EVAL;
      pdd_pkg::S_EVAL: begin
        if (item_q.action == pdd_pkg::ACT_SAMPLE && !deployed_q && rate_ok) begin
          state_d = pdd_pkg::S_MUL;
        end else begin
          state_d = pdd_pkg::S_DONE;
        end
      end
      pdd_pkg::S_MUL:  state_d = pdd_pkg::S_DIV;
      pdd_pkg::S_DIV:  if (div_done) state_d = pdd_pkg::S_FIN;
      pdd_pkg::S_FIN:  state_d = pdd_pkg::S_DONE;
      pdd_pkg::S_DONE: if (out_free) state_d = pdd_pkg::S_IDLE;
      default:         state_d = pdd_pkg::S_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_ready  = 1'b0;
    eval_en   = 1'b0;
    div_start = 1'b0;
    fin_en    = 1'b0;
    out_load  = 1'b0;
    case (state_q)
      pdd_pkg::S_IDLE: in_ready  = 1'b1;
      pdd_pkg::S_EVAL: eval_en   = 1'b1;
      pdd_pkg::S_MUL:  div_start = 1'b1;
      pdd_pkg::S_DIV:  ;
      pdd_pkg::S_FIN:  fin_en    = 1'b1;
      pdd_pkg::S_DONE: out_load  = out_free;
      default:         ;
    endcase
  end

  assign out_free   = !out_valid_q || out_o.ready;
  assign item_load  = in_ready && in_i.valid;
  assign in_i.ready = in_ready;
  assign clr_state  = eval_en && item_q.action == pdd_pkg::ACT_ARM;

  // gap, altitude magnitude and altitude delta in both directions
  assign alt_ext  = {item_q.altitude_cm[pdd_pkg::AltW-1], item_q.altitude_cm};
  assign last_ext = {last_alt_q[pdd_pkg::AltW-1], last_alt_q};
  assign d_pos    = alt_ext - last_ext;
  assign d_neg    = last_ext - alt_ext;
  assign alt_neg  = '0 - alt_ext;
  assign alt_mag  = item_q.altitude_cm[pdd_pkg::AltW-1] ? alt_neg[pdd_pkg::MagW-1:0]
                                                         : alt_ext[pdd_pkg::MagW-1:0];
  assign gap      = item_q.time_ms - last_time_q;
  assign rate_ok  = (last_time_q != '0) && (item_q.time_ms > last_time_q) &&
                    (gap < {{(pdd_pkg::TimeW-pdd_pkg::GapW){1'b0}}, cfg.max_time_gap}) &&
                    (alt_mag < {1'b0, cfg.altitude_limit});

  // scale the delta magnitude, the divider registers the product
  assign product = {{pdd_pkg::MulKW{1'b0}}, dmag_q} * pdd_pkg::DivW'(pdd_pkg::MulK);

  pdd_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (product),
    .divisor_i  (gap_q),
    .done_o     (div_done),
    .quotient_o (quo)
  );

  // sign and saturation of the quotient
  always_comb begin
    if (!dneg_q) begin
      if (quo[pdd_pkg::DivW-1:pdd_pkg::AltW-1] != '0) begin
        rate_sat = {1'b0, {(pdd_pkg::AltW-1){1'b1}}};
      end else begin
        rate_sat = $signed(quo[pdd_pkg::AltW-1:0]);
      end
    end else begin
      if (quo[pdd_pkg::DivW-1:pdd_pkg::AltW] != '0 ||
          (quo[pdd_pkg::AltW-1] && quo[pdd_pkg::AltW-2:0] != '0)) begin
        rate_sat = {1'b1, {(pdd_pkg::AltW-1){1'b0}}};
      end else begin
        rate_sat = $signed('0 - quo[pdd_pkg::AltW-1:0]);
      end
    end
  end

  assign rate_pos = !dneg_q && quo != '0;
  assign fire     = rate_pos &&
                    quo <= {{(pdd_pkg::DivW-pdd_pkg::ThrW){1'b0}}, cfg.velocity_threshold} &&
                    $signed(item_q.altitude_cm) >= $signed(cfg.min_altitude);

  // control and history registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pdd_pkg::S_IDLE;
      out_valid_q <= 1'b0;
      deployed_q  <= 1'b0;
      last_alt_q  <= '0;
      last_time_q <= '0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      if (clr_state) begin
        deployed_q  <= 1'b0;
        last_alt_q  <= '0;
        last_time_q <= '0;
      end else if (eval_en && !deployed_q) begin
        last_alt_q  <= item_q.altitude_cm;
        last_time_q <= item_q.time_ms;
      end
      if (fin_en && fire) begin
        deployed_q <= 1'b1;
      end
    end
  end

  // word and result registers
  always_ff @(posedge clk_i) begin
    if (item_load) begin
      item_q <= in_i.data;
    end
    if (eval_en) begin
      gap_q              <= gap[pdd_pkg::GapW-1:0];
      dneg_q             <= d_pos[pdd_pkg::AltW];
      dmag_q             <= d_pos[pdd_pkg::AltW] ? d_neg[pdd_pkg::MagW-1:0]
                                                 : d_pos[pdd_pkg::MagW-1:0];
      res_q.deploy_now   <= 1'b0;
      res_q.rate_valid   <= 1'b0;
      res_q.climb_rate   <= '0;
      res_q.deployed     <= (item_q.action == pdd_pkg::ACT_ARM) ? 1'b0 : deployed_q;
    end
    if (fin_en) begin
      res_q.deploy_now   <= fire;
      res_q.rate_valid   <= 1'b1;
      res_q.climb_rate   <= rate_sat;
      res_q.deployed     <= fire;
    end
    if (out_load) begin
      out_q <= res_q;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

  // checks
  a_fire_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.deploy_now |-> out_q.rate_valid && out_q.deployed)
    else $error("deploy word without rate or latch");

  a_no_rate_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_q.rate_valid |-> out_q.climb_rate == '0)
    else $error("climb rate non-zero without a valid rate");

  a_latch_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(deployed_q) |-> $past(clr_state))
    else $error("deployed latch cleared without an arm word");

endmodule

// ----- rtl/pdd_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// pdd_cfg_regs
// Register file for threshold, minimum altitude, gap and altitude limit.
// ----------------------------------------------------------------------------
module pdd_cfg_regs (
  input  logic          clk_i,
  input  logic          rst_ni,
  pdd_cfg_if.sink       cfg_i,
  output pdd_pkg::cfg_t cfg_o
);

  pdd_pkg::cfg_t regs_q, regs_d;

  // writes are always taken
  assign cfg_i.ready = 1'b1;

  // register write decode
  always_comb begin
    regs_d = regs_q;
    if (cfg_i.valid) begin
      case (cfg_i.data.index)
        pdd_pkg::CFG_VEL_THR:
          regs_d.velocity_threshold = cfg_i.data.value[pdd_pkg::ThrW-1:0];
        pdd_pkg::CFG_MIN_ALT:
          regs_d.min_altitude = $signed(cfg_i.data.value[pdd_pkg::AltW-1:0]);
        pdd_pkg::CFG_MAX_GAP:
          regs_d.max_time_gap = cfg_i.data.value[pdd_pkg::GapW-1:0];
        pdd_pkg::CFG_ALT_LIMIT:
          regs_d.altitude_limit = cfg_i.data.value[pdd_pkg::LimW-1:0];
        default: regs_d = regs_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      regs_q.velocity_threshold <= pdd_pkg::RstVelThr;
      regs_q.min_altitude       <= pdd_pkg::RstMinAlt;
      regs_q.max_time_gap       <= pdd_pkg::RstMaxGap;
      regs_q.altitude_limit     <= pdd_pkg::RstAltLim;
    end else begin
      regs_q <= regs_d;
    end
  end

  assign cfg_o = regs_q;

endmodule

// ----- rtl/pdd_div.sv -----
// ----------------------------------------------------------------------------
// pdd_div
// Radix-2 restoring divider, one quotient bit per cycle, unsigned operands.
// ----------------------------------------------------------------------------
module pdd_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [pdd_pkg::DivW-1:0]   dividend_i,
  input  logic [pdd_pkg::GapW-1:0]   divisor_i,
  output logic                       done_o,
  output logic [pdd_pkg::DivW-1:0]   quotient_o
);

  logic                          busy_q, busy_d;
  logic                          done_q, done_d;
  logic [pdd_pkg::DivCntW-1:0]   cnt_q, cnt_d;
  logic [pdd_pkg::DivW-1:0]      quo_q, quo_d;
  logic [pdd_pkg::GapW-1:0]      rem_q, rem_d;
  logic [pdd_pkg::GapW-1:0]      dvs_q;
  logic [pdd_pkg::GapW:0]        rem_sh;
  logic [pdd_pkg::GapW+1:0]      diff;
  logic                          last_step;

  // one restoring step
  assign rem_sh    = {rem_q, quo_q[pdd_pkg::DivW-1]};
  assign diff      = {1'b0, rem_sh} - {2'b00, dvs_q};
  assign last_step = (cnt_q == pdd_pkg::DivCntW'(pdd_pkg::DivW - 1));

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      quo_d  = dividend_i;
      rem_d  = '0;
    end else if (busy_q) begin
      if (!diff[pdd_pkg::GapW+1]) begin
        rem_d = diff[pdd_pkg::GapW-1:0];
        quo_d = {quo_q[pdd_pkg::DivW-2:0], 1'b1};
      end else begin
        rem_d = rem_sh[pdd_pkg::GapW-1:0];
        quo_d = {quo_q[pdd_pkg::DivW-2:0], 1'b0};
      end
      cnt_d = cnt_q + 1'b1;
      if (last_step) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    if (start_i) begin
      dvs_q <= divisor_i;
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

  // checks
  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q)
    else $error("divider started while busy");

  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy_q))
    else $error("divider done without a running division");

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> cnt_q <= pdd_pkg::DivCntW'(pdd_pkg::DivW - 1))
    else $error("divider step count out of range");

endmodule

// ----- test/tb_payload_deploy_detector_unit.sv -----
// ----------------------------------------------------------------------------
// tb_payload_deploy_detector_unit
// Self-checking bench for the payload deploy detector. Sample and arm words
// go in over the input channel with random gaps, results are drained with
// random back-pressure, and each result word is checked field by field
// against a climb rate predictor kept in step with every register write.
// ----------------------------------------------------------------------------
module tb_payload_deploy_detector_unit;

  localparam int unsigned StallLimit = 5000;
  localparam int unsigned DrainCycles = 60;
  localparam int unsigned ReportMax = 10;

  logic clk;
  logic rst_n;

  pdd_in_if  in_ch ();
  pdd_out_if out_ch ();
  pdd_cfg_if cfg_ch ();

  payload_deploy_detector_unit uut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_ch),
    .out_o  (out_ch),
    .cfg_i  (cfg_ch)
  );

  // clock
  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // predictor state and register copy
  pdd_pkg::cfg_t m_cfg = '{pdd_pkg::RstVelThr, pdd_pkg::RstMinAlt,
                           pdd_pkg::RstMaxGap, pdd_pkg::RstAltLim};
  logic                            m_deployed = 1'b0;
  logic signed [pdd_pkg::AltW-1:0] m_last_alt = '0;
  logic [pdd_pkg::TimeW-1:0]       m_last_time = '0;

  pdd_pkg::out_word_t expected_words[$];
  int        mismatches = 0;
  int        idle_cycles = 0;
  int        send_calm = 0;
  int        drain_calm = 0;

  // climb rate and deploy decision for one word, updating the history
  function automatic pdd_pkg::out_word_t predict_climb(pdd_pkg::in_word_t w);
    pdd_pkg::out_word_t        r;
    longint                    alt;
    longint                    mag;
    longint                    gap;
    longint                    rate;
    logic [pdd_pkg::TimeW-1:0] gap32;
    r = '0;
    if (w.action == pdd_pkg::ACT_ARM) begin
      m_deployed  = 1'b0;
      m_last_alt  = '0;
      m_last_time = '0;
    end else if (!m_deployed) begin
      alt = longint'($signed(w.altitude_cm));
      if (m_last_time != '0 && w.time_ms > m_last_time) begin
        gap32 = w.time_ms - m_last_time;
        gap   = longint'(gap32);
        mag   = (alt < 0) ? -alt : alt;
        if (gap < longint'(m_cfg.max_time_gap) &&
            mag < longint'(m_cfg.altitude_limit)) begin
          rate = ((alt - longint'($signed(m_last_alt))) * 1000) / gap;
          if (rate > 64'sd2147483647) rate = 64'sd2147483647;
          if (rate < -64'sd2147483648) rate = -64'sd2147483648;
          r.rate_valid = 1'b1;
          r.climb_rate = 32'(rate);
          if (rate > 0 && rate <= longint'(m_cfg.velocity_threshold) &&
              alt >= longint'($signed(m_cfg.min_altitude))) begin
            r.deploy_now = 1'b1;
            m_deployed   = 1'b1;
          end
        end
      end
      m_last_alt  = w.altitude_cm;
      m_last_time = w.time_ms;
    end
    r.deployed = m_deployed;
    return r;
  endfunction

  // idle length: mostly short, a few long, with calm stretches of none
  function automatic int pick_gap(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      calm = $urandom_range(10, 40);
      return 0;
    end
    if (r < 40) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 20);
    return $urandom_range(50, 200);
  endfunction

  function automatic logic signed [pdd_pkg::AltW-1:0] clamp32(longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return 32'(v);
  endfunction

  // send one word and record its expected result on acceptance
  task automatic send_word(pdd_pkg::in_word_t w);
    int gap;
    gap = pick_gap(send_calm);
    @(negedge clk);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= w;
    do @(posedge clk); while (!in_ch.ready);
    expected_words.push_back(predict_climb(w));
  endtask

  task automatic sample(logic signed [pdd_pkg::AltW-1:0] alt,
                        logic [pdd_pkg::TimeW-1:0] t);
    send_word('{action: pdd_pkg::ACT_SAMPLE, altitude_cm: alt, time_ms: t});
  endtask

  task automatic arm();
    send_word('{action: pdd_pkg::ACT_ARM, altitude_cm: '0, time_ms: '0});
  endtask

  // let the block run dry before touching registers
  task automatic settle();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(pdd_pkg::pdd_cfg_idx_e idx,
                           logic [pdd_pkg::CfgDataW-1:0] value);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= '{index: idx, value: value};
    do @(posedge clk); while (!cfg_ch.ready);
    case (idx)
      pdd_pkg::CFG_VEL_THR:   m_cfg.velocity_threshold = value[pdd_pkg::ThrW-1:0];
      pdd_pkg::CFG_MIN_ALT:   m_cfg.min_altitude = value;
      pdd_pkg::CFG_MAX_GAP:   m_cfg.max_time_gap = value[pdd_pkg::GapW-1:0];
      pdd_pkg::CFG_ALT_LIMIT: m_cfg.altitude_limit = value[pdd_pkg::LimW-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // default registers: slow climb above the minimum fires once
  task automatic test_default_deploy();
    arm();
    sample(32'sd130000, 32'd100);
    sample(32'sd130010, 32'd200);
    sample(32'sd130020, 32'd300);
    arm();
  endtask

  // zero timestamp, stale or equal time, gap at and below the limit
  task automatic test_time_rejects();
    sample(32'sd0, 32'd0);
    sample(32'sd10, 32'd50);
    sample(32'sd20, 32'd50);
    sample(32'sd30, 32'd40);
    sample(32'sd100, 32'd1039);
    sample(32'sd110, 32'd2039);
  endtask

  // altitude at the limit edges, most negative value, truncation toward zero
  task automatic test_altitude_edges();
    sample(32'sd9999999, 32'd3000);
    sample(32'sd10000000, 32'd3010);
    sample(-32'sd9999999, 32'd3020);
    sample(32'sh80000000, 32'd3030);
    sample(32'sh7fffffff, 32'd3040);
    sample(-32'sd10, 32'd3050);
    sample(-32'sd11, 32'd3053);
  endtask

  // rates beyond 32 bits saturate at both ends
  task automatic test_saturation();
    settle();
    write_reg(pdd_pkg::CFG_ALT_LIMIT, 32'h7fffffff);
    write_reg(pdd_pkg::CFG_MAX_GAP, 32'd65535);
    arm();
    sample(-32'sd2147483646, 32'd1);
    sample(32'sd2147483646, 32'd2);
    sample(-32'sd2147483646, 32'd3);
    sample(32'sd2147483646, 32'd65538);
  endtask

  // threshold and minimum at their extremes, zero gap and zero limit
  task automatic test_register_extremes();
    settle();
    write_reg(pdd_pkg::CFG_VEL_THR, 32'd0);
    write_reg(pdd_pkg::CFG_MIN_ALT, 32'h80000000);
    write_reg(pdd_pkg::CFG_ALT_LIMIT, 32'd1000);
    write_reg(pdd_pkg::CFG_MAX_GAP, 32'd1000);
    arm();
    sample(32'sd0, 32'd10);
    sample(32'sd1, 32'd20);
    settle();
    write_reg(pdd_pkg::CFG_VEL_THR, 32'd65535);
    write_reg(pdd_pkg::CFG_MIN_ALT, 32'h7fffffff);
    sample(32'sd2, 32'd30);
    settle();
    write_reg(pdd_pkg::CFG_MIN_ALT, 32'h80000000);
    sample(32'sd3, 32'd40);
    settle();
    write_reg(pdd_pkg::CFG_MAX_GAP, 32'd0);
    arm();
    sample(32'sd5, 32'd1);
    sample(32'sd6, 32'd2);
    settle();
    write_reg(pdd_pkg::CFG_MAX_GAP, 32'd1000);
    write_reg(pdd_pkg::CFG_ALT_LIMIT, 32'd0);
    sample(32'sd7, 32'd3);
  endtask

  // random flights under random register settings, with noise words
  task automatic test_random_flights();
    longint fl_time;
    longint fl_alt;
    longint step;
    longint target;
    longint span;
    int     r;
    int     thr;
    logic [pdd_pkg::CfgDataW-1:0] v;
    pdd_pkg::in_word_t w;
    for (int phase = 0; phase < 8; phase++) begin
      settle();
      r = $urandom_range(0, 9);
      v = (r == 0) ? 32'd0 : (r == 1) ? 32'd65535 : 32'($urandom_range(50, 3000));
      write_reg(pdd_pkg::CFG_VEL_THR, v);
      r = $urandom_range(0, 9);
      v = (r == 0) ? 32'h80000000 : (r == 1) ? 32'h7fffffff :
          32'($signed($urandom_range(0, 300000)) - 50000);
      write_reg(pdd_pkg::CFG_MIN_ALT, v);
      r = $urandom_range(0, 9);
      v = (r == 0) ? 32'd1 : (r == 1) ? 32'd65535 : 32'($urandom_range(50, 2000));
      write_reg(pdd_pkg::CFG_MAX_GAP, v);
      r = $urandom_range(0, 9);
      v = (r == 0) ? 32'd1 : (r == 1) ? 32'h7fffffff :
          32'($urandom_range(400000, 20000000));
      write_reg(pdd_pkg::CFG_ALT_LIMIT, v);
      thr     = int'(m_cfg.velocity_threshold);
      fl_time = $urandom_range(1, 1000000);
      fl_alt  = longint'($signed(m_cfg.min_altitude)) + $urandom_range(0, 2000) - 1000;
      for (int n = 0; n < 100; n++) begin
        r = $urandom_range(0, 99);
        if (r < 8) begin
          arm();
          fl_time = $urandom_range(1, 1000000);
          fl_alt  = longint'($signed(m_cfg.min_altitude)) + $urandom_range(0, 2000) - 1000;
        end else if (r < 22) begin
          w.action      = pdd_pkg::pdd_act_e'($urandom_range(0, 1));
          w.altitude_cm = $urandom;
          w.time_ms     = $urandom;
          send_word(w);
        end else begin
          r = $urandom_range(0, 99);
          if (r < 85) begin
            step = $urandom_range(1, (m_cfg.max_time_gap > 1) ? m_cfg.max_time_gap - 1 : 1);
          end else if (r < 93) begin
            step = longint'(m_cfg.max_time_gap) + $urandom_range(0, 100);
          end else begin
            step = 0;
          end
          span   = longint'(thr) * 2 + 20;
          target = longint'($urandom_range(0, 32'(span))) - thr / 2;
          fl_alt = longint'(clamp32(fl_alt + (target * step) / 1000));
          fl_time = (fl_time + step) & 64'hffffffff;
          w.action      = pdd_pkg::ACT_SAMPLE;
          w.altitude_cm = clamp32(fl_alt);
          w.time_ms     = (r >= 97) ? 32'd0 : 32'(fl_time);
          send_word(w);
        end
      end
    end
  endtask

  // result checking against the oldest expectation
  always @(posedge clk) begin
    pdd_pkg::out_word_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_words.size() == 0) begin
        mismatches++;
        if (mismatches <= ReportMax)
          $display("unexpected result word: deploy=%0b valid=%0b rate=%0d deployed=%0b",
                   out_ch.data.deploy_now, out_ch.data.rate_valid,
                   $signed(out_ch.data.climb_rate), out_ch.data.deployed);
      end else begin
        want = expected_words.pop_front();
        if (out_ch.data.deploy_now !== want.deploy_now ||
            out_ch.data.rate_valid !== want.rate_valid ||
            out_ch.data.climb_rate !== want.climb_rate ||
            out_ch.data.deployed !== want.deployed) begin
          mismatches++;
          if (mismatches <= ReportMax)
            $display("result mismatch: exp deploy=%0b valid=%0b rate=%0d deployed=%0b, %s",
                     want.deploy_now, want.rate_valid, $signed(want.climb_rate),
                     want.deployed,
                     $sformatf("got deploy=%0b valid=%0b rate=%0d deployed=%0b",
                               out_ch.data.deploy_now, out_ch.data.rate_valid,
                               $signed(out_ch.data.climb_rate), out_ch.data.deployed));
        end
      end
    end
  end

  // watchdog on cycles with no word moving on any channel
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= StallLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  // result side back-pressure
  initial begin
    int gap;
    out_ch.ready = 1'b0;
    @(negedge clk);
    forever begin
      gap = pick_gap(drain_calm);
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
  end

  // main sequence
  initial begin
    in_ch.valid  = 1'b0;
    in_ch.data   = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data  = '0;
    rst_n        = 1'b0;
    repeat (11) @(negedge clk);
    rst_n = 1'b1;

    test_default_deploy();
    test_time_rejects();
    test_altitude_edges();
    test_saturation();
    test_register_extremes();
    test_random_flights();

    settle();
    repeat (DrainCycles) @(posedge clk);
    if (mismatches == 0 && expected_words.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
